// ----- hdl/tapm_pkg.sv -----
// ----------------------------------------------------------------------------
// tapm_pkg
// shared widths, constants and codes for the path-minimum lifting core
// ----------------------------------------------------------------------------
package tapm_pkg;

  localparam int NODE_COUNT  = 1024;
  localparam int LEVEL_COUNT = 21;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int LVL_W       = $clog2(LEVEL_COUNT);
  localparam int WEIGHT_W    = 20;
  localparam int COUNT_W     = NODE_W + 1;
  localparam int TBL_W       = NODE_W + WEIGHT_W;
  localparam int TBL_DEPTH   = NODE_COUNT * (1 << LVL_W);

  localparam logic [WEIGHT_W-1:0] WEIGHT_INF = '1;
  localparam logic [LVL_W-1:0]    LVL_TOP    = LVL_W'(LEVEL_COUNT - 1);

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

// ----- hdl/tapm_if.sv -----
// ----------------------------------------------------------------------------
// tapm_in_if / tapm_out_if
// valid/ready channels carrying request and result beats
// ----------------------------------------------------------------------------
interface tapm_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [tapm_pkg::NODE_W-1:0]    node_a;
  logic [tapm_pkg::NODE_W-1:0]    node_b;
  logic [tapm_pkg::WEIGHT_W-1:0]  weight;

  modport source (output valid, output mode, output node_a, output node_b,
                  output weight, input ready);
  modport sink   (input valid, input mode, input node_a, input node_b,
                  input weight, output ready);
endinterface

interface tapm_out_if;
  logic                           valid;
  logic                           ready;
  logic [tapm_pkg::WEIGHT_W-1:0]  min_weight;
  logic [tapm_pkg::NODE_W-1:0]    meeting_node;
  logic [tapm_pkg::COUNT_W-1:0]   path_count;
  logic                           same_tree;

  modport source (output valid, output min_weight, output meeting_node,
                  output path_count, output same_tree, input ready);
  modport sink   (input valid, input min_weight, input meeting_node,
                  input path_count, input same_tree, output ready);
endinterface

// ----- hdl/tree_ancestor_path_min_query_core.sv -----
// ----------------------------------------------------------------------------
// tree_ancestor_path_min_query_core
// binary-lifting lca and path-minimum engine over a forest
// ----------------------------------------------------------------------------
// One item at a time. An add reads the parent depth, writes level 0 and then,
// per further level, reads the middle ancestor's row from the lifting ram and
// then writes the new row. A query reads both depths, runs up to two lifting
// passes (first: table read, depth read of the jump target, compare; second:
// both table reads, compare), then combines the final edges and looks up the
// ancestor depth. The single lifting ram read port sets this order. Results
// sit in an output register, so a new request is taken while a result waits.
// Node 0 is the null root; its rows come from constants, never from the rams.
module tree_ancestor_path_min_query_core (
  input  logic        clk,
  input  logic        rst_n,
  tapm_in_if.sink     in_chan,
  tapm_out_if.source  out_chan
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE   = 5'd0;
  localparam logic [ST_W-1:0] S_ADD_D  = 5'd1;
  localparam logic [ST_W-1:0] S_ADD_L0 = 5'd2;
  localparam logic [ST_W-1:0] S_ADD_RD = 5'd3;
  localparam logic [ST_W-1:0] S_ADD_WR = 5'd4;
  localparam logic [ST_W-1:0] S_Q_DA   = 5'd5;
  localparam logic [ST_W-1:0] S_Q_DB   = 5'd6;
  localparam logic [ST_W-1:0] S_Q_SW   = 5'd7;
  localparam logic [ST_W-1:0] S_L1_RD  = 5'd8;
  localparam logic [ST_W-1:0] S_L1_DR  = 5'd9;
  localparam logic [ST_W-1:0] S_L1_CMP = 5'd10;
  localparam logic [ST_W-1:0] S_L1_END = 5'd11;
  localparam logic [ST_W-1:0] S_L2_RX  = 5'd12;
  localparam logic [ST_W-1:0] S_L2_RY  = 5'd13;
  localparam logic [ST_W-1:0] S_L2_CMP = 5'd14;
  localparam logic [ST_W-1:0] S_F_RX   = 5'd15;
  localparam logic [ST_W-1:0] S_F_RY   = 5'd16;
  localparam logic [ST_W-1:0] S_F_CMB  = 5'd17;
  localparam logic [ST_W-1:0] S_Q_DM   = 5'd18;
  localparam logic [ST_W-1:0] S_Q_OUT  = 5'd19;

  localparam int NW = tapm_pkg::NODE_W;
  localparam int WW = tapm_pkg::WEIGHT_W;
  localparam int LW = tapm_pkg::LVL_W;
  localparam int CW = tapm_pkg::COUNT_W;
  localparam int TAW = $clog2(tapm_pkg::TBL_DEPTH);

  logic [ST_W-1:0] state_r, state_nxt;
  logic [NW-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic [WW-1:0]   w_r, w_nxt;
  logic [LW-1:0]   lv_r, lv_nxt;
  logic [NW-1:0]   cur_anc_r, cur_anc_nxt;
  logic [WW-1:0]   cur_min_r, cur_min_nxt;
  logic [NW-1:0]   dx_r, dx_nxt, da_r, da_nxt, db_r, db_nxt;
  logic [WW-1:0]   best_r, best_nxt;
  logic [NW-1:0]   ax_r, ax_nxt, meet_r, meet_nxt;
  logic [WW-1:0]   mx_r, mx_nxt;
  logic            tz_r, dz_r;

  logic            out_valid_r, out_valid_nxt;
  logic [WW-1:0]   out_min_r, out_min_nxt;
  logic [NW-1:0]   out_meet_r, out_meet_nxt;
  logic [CW-1:0]   out_cnt_r, out_cnt_nxt;
  logic            out_same_r, out_same_nxt;

  // ram ports
  logic                      t_we;
  logic [TAW-1:0]            t_waddr, t_raddr;
  logic [tapm_pkg::TBL_W-1:0] t_wdata, t_rdata;
  logic                      d_we;
  logic [NW-1:0]             d_waddr, d_wdata, d_raddr, d_rdata;

  logic [NW-1:0] t_anc, dep;
  logic [WW-1:0] t_min, min3;
  logic          accept;

  tapm_ram #(.WIDTH(tapm_pkg::TBL_W), .DEPTH(tapm_pkg::TBL_DEPTH)) u_lift_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  tapm_ram #(.WIDTH(NW), .DEPTH(tapm_pkg::NODE_COUNT)) u_depth_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  // node 0 reads come from constants
  assign t_anc = tz_r ? '0 : t_rdata[tapm_pkg::TBL_W-1:WW];
  assign t_min = tz_r ? tapm_pkg::WEIGHT_INF : t_rdata[WW-1:0];
  assign dep   = dz_r ? '0 : d_rdata;

  // three-way minimum used by the second pass and final combine
  always_comb begin
    min3 = best_r;
    if (mx_r < min3) begin
      min3 = mx_r;
    end
    if (t_min < min3) begin
      min3 = t_min;
    end
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // sequencer and ram control
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    lv_nxt        = lv_r;
    cur_anc_nxt   = cur_anc_r;
    cur_min_nxt   = cur_min_r;
    dx_nxt        = dx_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    best_nxt      = best_r;
    ax_nxt        = ax_r;
    mx_nxt        = mx_r;
    meet_nxt      = meet_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_min_nxt   = out_min_r;
    out_meet_nxt  = out_meet_r;
    out_cnt_nxt   = out_cnt_r;
    out_same_nxt  = out_same_r;
    t_we          = 1'b0;
    t_waddr       = {x_r, lv_r};
    t_wdata       = {cur_anc_r, cur_min_r};
    t_raddr       = {y_r, lv_r};
    d_we          = 1'b0;
    d_waddr       = x_r;
    d_wdata       = dep + NW'(1);
    d_raddr       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_nxt = in_chan.node_a;
          y_nxt = in_chan.node_b;
          w_nxt = in_chan.weight;
          if (in_chan.mode == tapm_pkg::MODE_QUERY) begin
            state_nxt = S_Q_DA;
          end else if (in_chan.node_a != '0) begin
            state_nxt = S_ADD_D;
          end
        end
      end
      // add: parent depth, then level 0, then one read/write per level
      S_ADD_D: begin
        d_raddr   = y_r;
        state_nxt = S_ADD_L0;
      end
      S_ADD_L0: begin
        d_we        = 1'b1;
        t_we        = 1'b1;
        t_waddr     = {x_r, LW'(0)};
        t_wdata     = {y_r, w_r};
        cur_anc_nxt = y_r;
        cur_min_nxt = w_r;
        lv_nxt      = LW'(1);
        state_nxt   = S_ADD_RD;
      end
      S_ADD_RD: begin
        t_raddr   = {cur_anc_r, lv_r - LW'(1)};
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        t_we        = 1'b1;
        t_wdata     = {t_anc, (t_min < cur_min_r) ? t_min : cur_min_r};
        cur_anc_nxt = t_anc;
        cur_min_nxt = (t_min < cur_min_r) ? t_min : cur_min_r;
        if (lv_r == tapm_pkg::LVL_TOP) begin
          state_nxt = S_IDLE;
        end else begin
          lv_nxt    = lv_r + LW'(1);
          state_nxt = S_ADD_RD;
        end
      end
      // query: depths of both nodes, deeper one goes to y
      S_Q_DA: begin
        d_raddr   = x_r;
        state_nxt = S_Q_DB;
      end
      S_Q_DB: begin
        d_raddr   = y_r;
        da_nxt    = dep;
        state_nxt = S_Q_SW;
      end
      S_Q_SW: begin
        db_nxt   = dep;
        best_nxt = tapm_pkg::WEIGHT_INF;
        lv_nxt   = tapm_pkg::LVL_TOP;
        if (da_r > dep) begin
          x_nxt  = y_r;
          y_nxt  = x_r;
          dx_nxt = dep;
        end else begin
          dx_nxt = da_r;
        end
        state_nxt = S_L1_RD;
      end
      // first pass: lift y while the target stays at or below x's depth
      S_L1_RD: begin
        t_raddr   = {y_r, lv_r};
        state_nxt = S_L1_DR;
      end
      S_L1_DR: begin
        ax_nxt    = t_anc;
        mx_nxt    = t_min;
        d_raddr   = t_anc;
        state_nxt = S_L1_CMP;
      end
      S_L1_CMP: begin
        if (dep >= dx_r) begin
          best_nxt = (mx_r < best_r) ? mx_r : best_r;
          y_nxt    = ax_r;
        end
        if (lv_r == '0) begin
          state_nxt = S_L1_END;
        end else begin
          lv_nxt    = lv_r - LW'(1);
          state_nxt = S_L1_RD;
        end
      end
      S_L1_END: begin
        lv_nxt = tapm_pkg::LVL_TOP;
        if (x_r == y_r) begin
          meet_nxt  = x_r;
          state_nxt = S_Q_DM;
        end else begin
          state_nxt = S_L2_RX;
        end
      end
      // second pass: lift both while their ancestors differ
      S_L2_RX: begin
        t_raddr   = {x_r, lv_r};
        state_nxt = S_L2_RY;
      end
      S_L2_RY: begin
        t_raddr   = {y_r, lv_r};
        ax_nxt    = t_anc;
        mx_nxt    = t_min;
        state_nxt = S_L2_CMP;
      end
      S_L2_CMP: begin
        if (ax_r != t_anc) begin
          best_nxt = min3;
          x_nxt    = ax_r;
          y_nxt    = t_anc;
        end
        if (lv_r == '0) begin
          state_nxt = S_F_RX;
        end else begin
          lv_nxt    = lv_r - LW'(1);
          state_nxt = S_L2_RX;
        end
      end
      // final parent edges of both sides
      S_F_RX: begin
        t_raddr   = {x_r, LW'(0)};
        state_nxt = S_F_RY;
      end
      S_F_RY: begin
        t_raddr   = {y_r, LW'(0)};
        ax_nxt    = t_anc;
        mx_nxt    = t_min;
        state_nxt = S_F_CMB;
      end
      S_F_CMB: begin
        best_nxt  = min3;
        meet_nxt  = ax_r;
        state_nxt = S_Q_DM;
      end
      // ancestor depth, then result beat
      S_Q_DM: begin
        d_raddr   = meet_r;
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        d_raddr = meet_r;
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = best_r;
          out_meet_nxt  = meet_r;
          out_cnt_nxt   = CW'(CW'(da_r) + CW'(db_r) - {dep, 1'b0} + CW'(1));
          out_same_nxt  = (meet_r != '0);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lv_r        <= lv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    w_r        <= w_nxt;
    cur_anc_r  <= cur_anc_nxt;
    cur_min_r  <= cur_min_nxt;
    dx_r       <= dx_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    best_r     <= best_nxt;
    ax_r       <= ax_nxt;
    mx_r       <= mx_nxt;
    meet_r     <= meet_nxt;
    tz_r       <= (t_raddr[TAW-1:LW] == '0);
    dz_r       <= (d_raddr == '0);
    out_min_r  <= out_min_nxt;
    out_meet_r <= out_meet_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_same_r <= out_same_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.min_weight   = out_min_r;
  assign out_chan.meeting_node = out_meet_r;
  assign out_chan.path_count   = out_cnt_r;
  assign out_chan.same_tree    = out_same_r;

  // lifting level never passes the top level
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    lv_r <= tapm_pkg::LVL_TOP)
    else $error("lifting level out of range");

  // a new result beat only comes out of the final query step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_Q_OUT))
    else $error("result beat without finished query");

  // table writes only touch the row of a real added node
  a_tbl_row: assert property (@(posedge clk) disable iff (!rst_n)
    t_we |-> (t_waddr[TAW-1:LW] == x_r) && (x_r != '0))
    else $error("lifting table write to wrong row");

endmodule

// ----- hdl/tapm_ram.sv -----
// ----------------------------------------------------------------------------
// tapm_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tapm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/tree_ancestor_path_min_query_core_tb.sv -----
// ----------------------------------------------------------------------------
// tree_ancestor_path_min_query_core_tb
// builds random forests with add beats and checks every lca / path-minimum
// result against a local lifting-table predictor, with random idling on both
// channels and one long result stall
// ----------------------------------------------------------------------------
module tree_ancestor_path_min_query_core_tb;

  typedef struct packed {
    logic                          mode;
    logic [tapm_pkg::NODE_W-1:0]   node_a;
    logic [tapm_pkg::NODE_W-1:0]   node_b;
    logic [tapm_pkg::WEIGHT_W-1:0] weight;
  } req_t;

  typedef struct packed {
    logic [tapm_pkg::WEIGHT_W-1:0] min_weight;
    logic [tapm_pkg::NODE_W-1:0]   meeting_node;
    logic [tapm_pkg::COUNT_W-1:0]  path_count;
    logic                          same_tree;
  } path_res_t;

  localparam int IDLE_LIMIT = 8000;

  logic clk;
  logic rst_n;

  tapm_in_if  in_if ();
  tapm_out_if out_if ();

  tree_ancestor_path_min_query_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // predictor state: lifting rows and depths
  logic [tapm_pkg::NODE_W-1:0]   lift_anc   [tapm_pkg::NODE_COUNT][tapm_pkg::LEVEL_COUNT];
  logic [tapm_pkg::WEIGHT_W-1:0] lift_min   [tapm_pkg::NODE_COUNT][tapm_pkg::LEVEL_COUNT];
  logic [tapm_pkg::NODE_W-1:0]   node_depth [tapm_pkg::NODE_COUNT];

  req_t      pending_reqs[$];
  path_res_t expected_paths[$];
  int        added_nodes[$];
  bit        is_added [tapm_pkg::NODE_COUNT];
  int        fail_cnt;
  int        idle_cycles;
  int        beats_sent;
  int        results_seen;
  int        hold_cnt;
  bit        hold_done;

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [tapm_pkg::WEIGHT_W-1:0] wmin(
      logic [tapm_pkg::WEIGHT_W-1:0] p, logic [tapm_pkg::WEIGHT_W-1:0] q);
    return (p < q) ? p : q;
  endfunction

  // enter a node below its parent and fill all levels
  task automatic insert_node(req_t r);
    logic [tapm_pkg::NODE_W-1:0] a;
    logic [tapm_pkg::NODE_W-1:0] mid;
    a = r.node_a;
    if (a == 0) return;
    node_depth[a]  = node_depth[r.node_b] + 1'b1;
    lift_anc[a][0] = r.node_b;
    lift_min[a][0] = r.weight;
    for (int lv = 1; lv < tapm_pkg::LEVEL_COUNT; lv++) begin
      mid = lift_anc[a][lv-1];
      lift_anc[a][lv] = lift_anc[mid][lv-1];
      lift_min[a][lv] = wmin(lift_min[a][lv-1], lift_min[mid][lv-1]);
    end
  endtask

  // lift both nodes to their lowest common ancestor
  function automatic path_res_t lca_path(logic [tapm_pkg::NODE_W-1:0] qa,
                                         logic [tapm_pkg::NODE_W-1:0] qb);
    path_res_t                     res;
    logic [tapm_pkg::NODE_W-1:0]   x;
    logic [tapm_pkg::NODE_W-1:0]   y;
    logic [tapm_pkg::NODE_W-1:0]   t;
    logic [tapm_pkg::NODE_W-1:0]   up;
    logic [tapm_pkg::NODE_W-1:0]   meet;
    logic [tapm_pkg::WEIGHT_W-1:0] best;
    int                            cnt;
    x = qa;
    y = qb;
    best = tapm_pkg::WEIGHT_INF;
    if (node_depth[x] > node_depth[y]) begin
      t = x; x = y; y = t;
    end
    for (int lv = tapm_pkg::LEVEL_COUNT - 1; lv >= 0; lv--) begin
      up = lift_anc[y][lv];
      if (node_depth[up] >= node_depth[x]) begin
        best = wmin(best, lift_min[y][lv]);
        y = up;
      end
    end
    if (x == y) begin
      meet = x;
    end else begin
      for (int lv = tapm_pkg::LEVEL_COUNT - 1; lv >= 0; lv--) begin
        if (lift_anc[x][lv] != lift_anc[y][lv]) begin
          best = wmin(best, lift_min[x][lv]);
          best = wmin(best, lift_min[y][lv]);
          x = lift_anc[x][lv];
          y = lift_anc[y][lv];
        end
      end
      best = wmin(best, lift_min[x][0]);
      best = wmin(best, lift_min[y][0]);
      meet = lift_anc[x][0];
    end
    cnt = int'(node_depth[qa]) + int'(node_depth[qb]) - 2 * int'(node_depth[meet]) + 1;
    res.min_weight   = best;
    res.meeting_node = meet;
    res.path_count   = tapm_pkg::COUNT_W'(cnt);
    res.same_tree    = (meet != 0);
    return res;
  endfunction

  // stimulus helpers track which nodes hold defined rows
  task automatic push_add(int a, int p, logic [tapm_pkg::WEIGHT_W-1:0] w);
    req_t r;
    r.mode   = tapm_pkg::MODE_ADD;
    r.node_a = tapm_pkg::NODE_W'(a);
    r.node_b = tapm_pkg::NODE_W'(p);
    r.weight = w;
    pending_reqs = {pending_reqs, r};
    if (!is_added[a]) begin
      is_added[a] = 1'b1;
      added_nodes = {added_nodes, a};
    end
  endtask

  task automatic push_query(int a, int b);
    req_t r;
    r.mode   = tapm_pkg::MODE_QUERY;
    r.node_a = tapm_pkg::NODE_W'(a);
    r.node_b = tapm_pkg::NODE_W'(b);
    r.weight = tapm_pkg::WEIGHT_W'($urandom);
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic int pick_node();
    return added_nodes[$urandom_range(added_nodes.size() - 1)];
  endfunction

  function automatic logic [tapm_pkg::WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(9))
      0:       return tapm_pkg::WEIGHT_INF;
      1:       return '0;
      2:       return tapm_pkg::WEIGHT_INF - 1'b1;
      3, 4:    return tapm_pkg::WEIGHT_W'($urandom_range(15));
      default: return tapm_pkg::WEIGHT_W'($urandom);
    endcase
  endfunction

  // driver: offer the next request beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        beats_sent <= beats_sent + 1;
        if (in_if.mode == tapm_pkg::MODE_ADD)
          insert_node({in_if.mode, in_if.node_a, in_if.node_b, in_if.weight});
        else
          expected_paths = {expected_paths, lca_path(in_if.node_a, in_if.node_b)};
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_reqs.size() > 0 &&
            ((beats_sent > 700 && beats_sent < 1100) || $urandom_range(99) >= 6)) begin
          {in_if.mode, in_if.node_a, in_if.node_b, in_if.weight} <= pending_reqs.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result ready with idling and one long hold-off
  always @(posedge clk) begin
    path_res_t got;
    path_res_t exp_r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.min_weight, out_if.meeting_node, out_if.path_count, out_if.same_tree};
        results_seen <= results_seen + 1;
        if (expected_paths.size() == 0) begin
          $error("unexpected result beat");
          fail_cnt <= fail_cnt + 1;
        end else begin
          exp_r = expected_paths.pop_front();
          if (got.min_weight !== exp_r.min_weight) begin
            $error("min_weight exp %0d got %0d", exp_r.min_weight, got.min_weight);
            fail_cnt <= fail_cnt + 1;
          end
          if (got.meeting_node !== exp_r.meeting_node) begin
            $error("meeting_node exp %0d got %0d", exp_r.meeting_node, got.meeting_node);
            fail_cnt <= fail_cnt + 1;
          end
          if (got.path_count !== exp_r.path_count) begin
            $error("path_count exp %0d got %0d", exp_r.path_count, got.path_count);
            fail_cnt <= fail_cnt + 1;
          end
          if (got.same_tree !== exp_r.same_tree) begin
            $error("same_tree exp %0d got %0d", exp_r.same_tree, got.same_tree);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
      if (!hold_done && results_seen == 40) begin
        out_if.ready <= 1'b0;
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt == 600) hold_done <= 1'b1;
      end else if (results_seen > 300 && results_seen < 420) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 6);
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int a;
    int b;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.mode   = tapm_pkg::MODE_ADD;
    in_if.node_a = '0;
    in_if.node_b = '0;
    in_if.weight = '0;
    out_if.ready = 1'b0;
    fail_cnt     = 0;
    idle_cycles  = 0;
    beats_sent   = 0;
    results_seen = 0;
    hold_cnt     = 0;
    hold_done    = 1'b0;
    // null root row, zero depths, no nodes added
    for (int n = 0; n < tapm_pkg::NODE_COUNT; n++) begin
      node_depth[n] = '0;
      is_added[n]   = 1'b0;
      for (int lv = 0; lv < tapm_pkg::LEVEL_COUNT; lv++) begin
        lift_anc[0][lv] = '0;
        lift_min[0][lv] = tapm_pkg::WEIGHT_INF;
      end
    end

    // directed: chain, extremes, self query, null node, separate trees, re-add cycle
    push_add(1, 0, tapm_pkg::WEIGHT_INF);
    push_add(2, 1, '0);
    push_add(3, 2, tapm_pkg::WEIGHT_INF - 1'b1);
    push_add(1023, 1, 20'd5);
    push_add(512, 0, tapm_pkg::WEIGHT_INF);
    push_add(341, 512, 20'haaaaa);
    push_add(682, 341, 20'h55555);
    push_query(3, 1023);
    push_query(1023, 3);
    push_query(3, 3);
    push_query(1, 0);
    push_query(3, 1);
    push_query(682, 3);
    push_query(682, 512);
    push_query(1023, 1023);
    push_add(2, 3, 20'd7);
    push_query(2, 3);
    push_query(3, 1023);
    push_add(1, 0, tapm_pkg::WEIGHT_INF);
    push_query(2, 1);

    // random: forest growth with queries and re-adds
    for (int i = 0; i < 1880; i++) begin
      if ($urandom_range(99) < 55) begin
        a = (added_nodes.size() < 20 || $urandom_range(9) > 1) ?
            $urandom_range(1023, 1) : pick_node();
        b = ($urandom_range(9) == 0) ? 0 : pick_node();
        push_add(a, b, (b == 0) ? tapm_pkg::WEIGHT_INF : rand_weight());
      end else begin
        a = pick_node();
        case ($urandom_range(9))
          0:       b = 0;
          1:       b = a;
          default: b = pick_node();
        endcase
        push_query(a, b);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && !in_if.valid);
    wait (expected_paths.size() == 0);
    repeat (300) @(posedge clk);
    if (fail_cnt == 0 && expected_paths.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
